>>> rtl/chrd_pkg.sv
// shared types, constants and the cordic arctangent table for the ring detector
// no dependencies
package chrd_pkg;

    localparam int CfgIdxBits = 3;
    localparam int CfgDataBits = 20;
    localparam int AngBits = 32;
    localparam int CordicSteps = 32;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_RADIUS = 3'd0,
        REG_STRIP = 3'd1,
        REG_DETECTORS = 3'd2,
        REG_RINGS = 3'd3,
        REG_AXIAL = 3'd4,
        REG_COERCE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [18:0] radius;
        logic [15:0] strip_hgt;
        logic [12:0] detectors;
        logic [8:0]  rings;
        logic [19:0] axial_length;
        logic        coerce_edges;
    } t_cfg;

    function automatic logic [AngBits-1:0] atan_turn(input logic [4:0] i);
        logic [AngBits-1:0] v;
        unique case (i)
            5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001; default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/chrd_hit_lane.sv
// one hit lane: pipelined radial check, 32-stage cordic angle, sector and ring index
// depends on chrd_pkg; flows under a shared stage enable from the top level
module chrd_hit_lane #(
    parameter int COORD_BITS = 20,
    parameter int DET_INDEX_BITS = 12,
    parameter int RING_INDEX_BITS = 8,
    parameter int LAT = 36
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  chrd_pkg::t_cfg               i_cfg,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    output logic [RING_INDEX_BITS-1:0]   o_ring,
    output logic [DET_INDEX_BITS-1:0]    o_det,
    output logic                         o_inside
);
    import chrd_pkg::*;

    localparam int W = 63;               // cordic datapath width
    localparam int MB = COORD_BITS;      // magnitude bits
    localparam int SB = 2 * MB + 1;      // sum of squares bits
    localparam int CW = (SB > 44) ? SB : 45; // radial compare width
    localparam int TB = 42;              // axial work bits
    localparam int NS = CordicSteps;
    localparam int DB = 13 + AngBits;

    // ---------------- stage 0: magnitudes, squares, bounds
    logic [MB-1:0] mx, my;
    assign mx = i_x[COORD_BITS-1] ? MB'(-i_x) : MB'(i_x);
    assign my = i_y[COORD_BITS-1] ? MB'(-i_y) : MB'(i_y);

    logic [20:0] tol2, rad2;
    logic [21:0] a_w;
    logic [21:0] b_w;
    logic        b_pos;
    assign tol2 = 21'(i_cfg.strip_hgt) + 21'd256;
    assign rad2 = {i_cfg.radius, 1'b0} + 21'd0;
    assign a_w = 22'(rad2) + 22'(tol2);
    assign b_pos = rad2 > tol2;
    assign b_w = 22'(rad2) - 22'(tol2);

    logic [2*MB-1:0] r_sx, r_sy;
    logic [43:0]     r_aa, r_bb;
    logic            r_bpos;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= mx * mx;
            r_sy <= my * my;
            r_aa <= a_w * a_w;
            r_bb <= b_w * b_w;
            r_bpos <= b_pos;
        end
    end

    logic rad_ok;
    logic [SB-1:0] s_sum;
    logic [43:0] hi_v, lo_v;
    assign s_sum = SB'(r_sx) + SB'(r_sy);
    assign hi_v = r_aa >> 2;
    assign lo_v = r_bpos ? ((r_aa - r_aa) + ((r_bb + 44'd3) >> 2)) : 44'd0;
    assign rad_ok = (CW'(s_sum) >= CW'(lo_v)) && (CW'(s_sum) <= CW'(hi_v));

    // radial flag delay line
    logic [LAT-2:0] r_rad;
    always_ff @(posedge i_clk) begin
        if (i_en) r_rad <= {r_rad[LAT-3:0], rad_ok};
    end

    // ---------------- cordic: prep stage then 32 iterations
    logic signed [W-1:0] px, py;
    logic [AngBits-1:0]  pz;
    logic                pfix;
    always_comb begin
        px = W'(i_x) <<< (60 - COORD_BITS);
        py = W'(i_y) <<< (60 - COORD_BITS);
        pz = '0;
        pfix = 1'b0;
        if (i_y == '0) begin
            pfix = 1'b1;
            pz = i_x[COORD_BITS-1] ? 32'h80000000 : 32'h0;
        end else if (i_x == '0) begin
            pfix = 1'b1;
            pz = i_y[COORD_BITS-1] ? 32'hC0000000 : 32'h40000000;
        end else if (i_x[COORD_BITS-1]) begin
            px = -px;
            py = -py;
            pz = 32'h80000000;
        end
    end

    logic signed [W-1:0] r_cx [NS+1];
    logic signed [W-1:0] r_cy [NS+1];
    logic [AngBits-1:0]  r_cz [NS+1];
    logic                r_cf [NS+1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= px; r_cy[0] <= py; r_cz[0] <= pz; r_cf[0] <= pfix;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        logic signed [W-1:0] dx, dy;
        assign dx = r_cy[g] >>> g;
        assign dy = r_cx[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cf[g+1] <= r_cf[g];
                if (r_cf[g]) begin
                    r_cx[g+1] <= r_cx[g]; r_cy[g+1] <= r_cy[g]; r_cz[g+1] <= r_cz[g];
                end else if (r_cy[g] > 0) begin
                    r_cx[g+1] <= r_cx[g] + dx;
                    r_cy[g+1] <= r_cy[g] - dy;
                    r_cz[g+1] <= r_cz[g] + atan_turn(5'(g));
                end else begin
                    r_cx[g+1] <= r_cx[g] - dx;
                    r_cy[g+1] <= r_cy[g] + dy;
                    r_cz[g+1] <= r_cz[g] - atan_turn(5'(g));
                end
            end
        end
    end

    // sector: product stage then saturate
    logic [DB-1:0] r_prod;
    logic          r_azero;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= DB'(i_cfg.detectors) * DB'(r_cz[NS]);
            r_azero <= (r_cz[NS] == '0) || (i_cfg.detectors == '0);
        end
    end
    logic [12:0] d_full;
    logic [DET_INDEX_BITS-1:0] det_v;
    localparam logic [12:0] DMAX = 13'((32'd1 << DET_INDEX_BITS) - 1);
    assign d_full = r_azero ? 13'd0 : 13'((r_prod - DB'(1)) >> AngBits);
    assign det_v = (DET_INDEX_BITS < 13 && d_full > DMAX) ? DET_INDEX_BITS'(DMAX)
                                                         : DET_INDEX_BITS'(d_full);

    // sector path: prep, NS iterations and product, then delay to align with LAT
    localparam int DDL = LAT - 2 - NS;
    logic [DET_INDEX_BITS-1:0] r_dd [DDL+1];
    assign r_dd[0] = det_v;
    for (genvar k = 0; k < DDL; k++) begin : g_ddl
        always_ff @(posedge i_clk) begin
            if (i_en) r_dd[k+1] <= r_dd[k];
        end
    end

    // ---------------- axial: product, then serial quotient over the remaining stages
    logic signed [TB-1:0] r_n;
    logic                 r_zz;
    logic [19:0]          r_len;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= TB'($signed({1'b0, i_cfg.rings})) * TB'(i_z);
            r_zz <= (i_z == '0);
            r_len <= (i_cfg.axial_length == '0) ? 20'd1 : i_cfg.axial_length;
        end
    end

    // restoring division of |n| (41 bits) by len, 2 quotient bits per stage
    localparam int QB = 42;
    localparam int DS = QB / 2;
    logic [QB-1:0] r_q [DS+1];
    logic [20:0]   r_rm [DS+1];
    logic [19:0]   r_dl [DS+1];
    logic          r_ng [DS+1];
    logic          r_dz [DS+1];
    logic [TB-1:0] n_mag;
    assign n_mag = r_n[TB-1] ? TB'(-r_n) : TB'(r_n);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= QB'(n_mag); r_rm[0] <= '0; r_dl[0] <= r_len;
            r_ng[0] <= r_n[TB-1]; r_dz[0] <= r_zz;
        end
    end
    for (genvar d = 0; d < DS; d++) begin : g_div
        logic [21:0] t1, t2;
        logic [20:0] m1, m2;
        logic        b1, b2;
        assign t1 = {r_rm[d], r_q[d][QB-1]};
        assign b1 = t1 >= 22'(r_dl[d]);
        assign m1 = b1 ? 21'(t1 - 22'(r_dl[d])) : t1[20:0];
        assign t2 = {m1, r_q[d][QB-2]};
        assign b2 = t2 >= 22'(r_dl[d]);
        assign m2 = b2 ? 21'(t2 - 22'(r_dl[d])) : t2[20:0];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[d+1] <= {r_q[d][QB-3:0], b1, b2};
                r_rm[d+1] <= m2;
                r_dl[d+1] <= r_dl[d];
                r_ng[d+1] <= r_ng[d];
                r_dz[d+1] <= r_dz[d];
            end
        end
    end

    // ring index from quotient, then delay to lane output
    logic signed [QB:0] tval;
    always_comb begin
        if (r_dz[DS]) tval = '0;
        else if (r_ng[DS]) tval = -$signed({1'b0, r_q[DS]}) - 1;
        else tval = $signed({1'b0, r_q[DS]}) + ((r_rm[DS] != '0) ? 1 : 0) - 1;
    end

    // axial path: 1 + 1 + DS stages, then delay to align with LAT
    localparam int AXD = LAT - 2 - DS;
    logic [8:0] r_rt [AXD+1];
    logic       r_rneg [AXD+1];
    logic       r_rbig [AXD+1];
    assign r_rt[0] = tval[8:0];
    assign r_rneg[0] = tval[QB];
    assign r_rbig[0] = !tval[QB] && (tval[QB-1:9] != '0);
    for (genvar k = 0; k < AXD; k++) begin : g_axd
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt[k+1] <= r_rt[k]; r_rneg[k+1] <= r_rneg[k]; r_rbig[k+1] <= r_rbig[k];
            end
        end
    end

    logic       in_rng;
    logic [8:0] rmax, rout;
    assign rmax = (i_cfg.rings == '0) ? 9'd0 : i_cfg.rings - 9'd1;
    assign in_rng = !r_rneg[AXD] && !r_rbig[AXD] && (r_rt[AXD] < i_cfg.rings);
    always_comb begin
        if (r_rneg[AXD]) rout = '0;
        else if (r_rbig[AXD] || r_rt[AXD] > rmax) rout = rmax;
        else rout = r_rt[AXD];
    end
    localparam logic [8:0] RMX = 9'((32'd1 << RING_INDEX_BITS) - 1);

    assign o_ring = (RING_INDEX_BITS < 9 && rout > RMX) ? RING_INDEX_BITS'(RMX)
                                                       : RING_INDEX_BITS'(rout);
    assign o_det = r_dd[DDL];
    assign o_inside = r_rad[LAT-2] && (i_cfg.coerce_edges || in_rng);
endmodule

>>> rtl/coincidence_hit_to_ring_detector.sv
// top level: two hit lanes, a flag merge and an output register with skid buffer
// depends on chrd_pkg and chrd_hit_lane
//
//  channel   | dir | handshake           | content
//  s_axis    | in  | tvalid/tready       | tdata: hit_a_x,y,z, hit_b_x,y,z
//  m_axis    | out | tvalid/tready       | tdata: ring_a,det_a,ring_b,det_b,flags
//  cfg       | in  | i_cfg_we            | index, data, no read-back
//
// one request enters per cycle while the pipeline is not stalled; results leave after the
// 32-stage cordic angle pipeline plus radial, sector and output stages
// reset (synchronous, active low) clears valid bits and loads register defaults
// the pipeline advances only while its tail has room; a two-entry output
// queue keeps tready high while one finished result waits
module coincidence_hit_to_ring_detector #(
    parameter int COORD_BITS = 20,
    parameter int DET_INDEX_BITS = 12,
    parameter int RING_INDEX_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [chrd_pkg::CfgIdxBits-1:0]    i_cfg_idx,
    input  logic [chrd_pkg::CfgDataBits-1:0]   i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // hit_a_x, hit_a_y, hit_a_z, hit_b_x, hit_b_y, hit_b_z from bit 0, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ring_a, det_a, ring_b, det_b, hit_a_inside, hit_b_inside, event_valid
    output logic [((2*(DET_INDEX_BITS+RING_INDEX_BITS)+3+7)/8)*8-1:0] m_axis_tdata
);
    import chrd_pkg::*;

    localparam int LAT = 36;
    localparam int OW = 2 * (DET_INDEX_BITS + RING_INDEX_BITS) + 3;
    localparam int OTW = ((OW + 7) / 8) * 8;
    localparam int C = COORD_BITS;

    // configuration registers
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{radius: 19'd112000, strip_hgt: 16'd1536, detectors: 13'd384,
                       rings: 9'd1, axial_length: 20'd128000, coerce_edges: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:    r_cfg.radius <= i_cfg_data[18:0];
                REG_STRIP:     r_cfg.strip_hgt <= i_cfg_data[15:0];
                REG_DETECTORS: r_cfg.detectors <= i_cfg_data[12:0];
                REG_RINGS:     r_cfg.rings <= i_cfg_data[8:0];
                REG_AXIAL:     r_cfg.axial_length <= i_cfg_data[19:0];
                REG_COERCE:    r_cfg.coerce_edges <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline valid shift and stall; output queue of two
    logic [LAT-1:0] r_vld;
    logic [OW-1:0]  r_q0, r_q1;
    logic [1:0]     r_cnt;
    logic           en, pop, push;
    // advance when the result leaving the lanes can be stored
    assign en = !r_vld[LAT-1] || (r_cnt < 2'd2) || m_axis_tready;
    assign s_axis_tready = en;
    assign push = en && r_vld[LAT-1];
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    logic [RING_INDEX_BITS-1:0] ring_a, ring_b;
    logic [DET_INDEX_BITS-1:0]  det_a, det_b;
    logic                       in_a, in_b;

    chrd_hit_lane #(.COORD_BITS(C), .DET_INDEX_BITS(DET_INDEX_BITS),
                    .RING_INDEX_BITS(RING_INDEX_BITS), .LAT(LAT)) u_lane_a (
        .i_clk(i_clk), .i_en(en), .i_cfg(r_cfg),
        .i_x(s_axis_tdata[C-1:0]), .i_y(s_axis_tdata[2*C-1:C]),
        .i_z(s_axis_tdata[3*C-1:2*C]),
        .o_ring(ring_a), .o_det(det_a), .o_inside(in_a));

    chrd_hit_lane #(.COORD_BITS(C), .DET_INDEX_BITS(DET_INDEX_BITS),
                    .RING_INDEX_BITS(RING_INDEX_BITS), .LAT(LAT)) u_lane_b (
        .i_clk(i_clk), .i_en(en), .i_cfg(r_cfg),
        .i_x(s_axis_tdata[4*C-1:3*C]), .i_y(s_axis_tdata[5*C-1:4*C]),
        .i_z(s_axis_tdata[6*C-1:5*C]),
        .o_ring(ring_b), .o_det(det_b), .o_inside(in_b));

    // merge: both hits inside makes the event valid
    logic [OW-1:0] merged;
    assign merged = {in_a & in_b, in_b, in_a, det_b, ring_b, det_a, ring_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        priority if (pop && push && r_cnt == 2'd1) r_q0 <= merged;
        else if (pop && push) begin
            r_q0 <= r_q1; r_q1 <= merged;
        end else if (pop) r_q0 <= r_q1;
        else if (push && r_cnt == 2'd0) r_q0 <= merged;
        else if (push) r_q1 <= merged;
    end

    assign m_axis_tvalid = r_cnt != 2'd0;
    assign m_axis_tdata = OTW'(r_q0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && r_cnt == 2'd2))
        else $error("output queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
endmodule

>>> tb/tb_chrd_checker.sv
`timescale 1ns / 100ps
// checker for the ring detector: watches both stream channels and the cfg port,
// predicts each result from its own copy of the registers; depends on chrd_pkg
module tb_chrd_checker #(
    parameter int COORD_BITS = 20,
    parameter int DET_INDEX_BITS = 12,
    parameter int RING_INDEX_BITS = 8,
    parameter int IN_W = ((6*COORD_BITS+7)/8)*8,
    parameter int OUT_W = ((2*(DET_INDEX_BITS+RING_INDEX_BITS)+3+7)/8)*8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [chrd_pkg::CfgIdxBits-1:0]  i_cfg_idx,
    input  logic [chrd_pkg::CfgDataBits-1:0] i_cfg_data,
    input  logic                             i_s_valid,
    input  logic                             i_s_ready,
    input  logic [IN_W-1:0]                  i_s_data,
    input  logic                             i_m_valid,
    input  logic                             i_m_ready,
    input  logic [OUT_W-1:0]                 i_m_data,
    output int                               o_errors,
    output int                               o_pending
);
    import chrd_pkg::*;

    localparam int RB = RING_INDEX_BITS;
    localparam int DB = DET_INDEX_BITS;

    typedef struct packed {
        logic          event_valid;
        logic          hit_b_inside;
        logic          hit_a_inside;
        logic [DB-1:0] det_b;
        logic [RB-1:0] ring_b;
        logic [DB-1:0] det_a;
        logic [RB-1:0] ring_a;
    } t_event_out;

    t_cfg       geom;
    t_event_out event_q[$];

    localparam logic [31:0] ATAN_TBL [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000};

    // angle as a fraction of a full turn, 2^32 = 2pi
    function automatic logic [31:0] turn_of(longint x, longint y);
        logic [31:0] ang;
        longint dx, dy;
        if (y == 0) return (x >= 0) ? 32'h0 : 32'h80000000;
        if (x == 0) return (y > 0) ? 32'h40000000 : 32'hC0000000;
        ang = 32'h0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        x = x <<< (60 - COORD_BITS);
        y = y <<< (60 - COORD_BITS);
        for (int i = 0; i < 32; i++) begin
            // >>> on longint floors toward minus infinity
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; ang += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_TBL[i];
            end
        end
        return ang;
    endfunction

    task automatic locate_hit(input logic [COORD_BITS-1:0] rx, ry, rz,
                              output logic [RB-1:0] ring, output logic [DB-1:0] det,
                              output logic hit_ok);
        longint x, y, z, s, a, b, hi, lo, n, len, t, c, rmax, rout;
        longint unsigned d;
        logic [31:0] ang;
        logic rad_ok, in_rng;
        x = longint'($signed(rx));
        y = longint'($signed(ry));
        z = longint'($signed(rz));
        s = x*x + y*y;
        a = 2*longint'(geom.radius) + longint'(geom.strip_hgt) + 256;
        b = 2*longint'(geom.radius) - longint'(geom.strip_hgt) - 256;
        hi = (a*a) / 4;
        lo = (b > 0) ? (b*b + 3) / 4 : 0;
        rad_ok = (s >= lo) && (s <= hi);

        ang = turn_of(x, y);
        if (ang == 0 || geom.detectors == 0) d = 0;
        else d = (longint'(geom.detectors) * longint'(ang) - 1) >> 32;
        if (d > (1 << DB) - 1) d = (1 << DB) - 1;

        len = (geom.axial_length == 0) ? 1 : longint'(geom.axial_length);
        if (z == 0) t = 0;
        else begin
            n = longint'(geom.rings) * z;
            c = (n > 0) ? (n + len - 1) / len : -((-n) / len);
            t = c - 1;
        end
        in_rng = (t >= 0) && (t < longint'(geom.rings));
        rmax = (geom.rings == 0) ? 0 : longint'(geom.rings) - 1;
        rout = (t < 0) ? 0 : (t > rmax ? rmax : t);
        if (rout > (1 << RB) - 1) rout = (1 << RB) - 1;
        ring = rout[RB-1:0];
        det = d[DB-1:0];
        hit_ok = rad_ok && (geom.coerce_edges || in_rng);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_event_out ev, got;
        if (!i_rst_n) begin
            geom.radius <= 19'd112000;
            geom.strip_hgt <= 16'd1536;
            geom.detectors <= 13'd384;
            geom.rings <= 9'd1;
            geom.axial_length <= 20'd128000;
            geom.coerce_edges <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_RADIUS: geom.radius <= i_cfg_data[18:0];
                    REG_STRIP: geom.strip_hgt <= i_cfg_data[15:0];
                    REG_DETECTORS: geom.detectors <= i_cfg_data[12:0];
                    REG_RINGS: geom.rings <= i_cfg_data[8:0];
                    REG_AXIAL: geom.axial_length <= i_cfg_data[19:0];
                    REG_COERCE: geom.coerce_edges <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                locate_hit(i_s_data[0 +: COORD_BITS], i_s_data[COORD_BITS +: COORD_BITS],
                           i_s_data[2*COORD_BITS +: COORD_BITS],
                           ev.ring_a, ev.det_a, ev.hit_a_inside);
                locate_hit(i_s_data[3*COORD_BITS +: COORD_BITS],
                           i_s_data[4*COORD_BITS +: COORD_BITS],
                           i_s_data[5*COORD_BITS +: COORD_BITS],
                           ev.ring_b, ev.det_b, ev.hit_b_inside);
                ev.event_valid = ev.hit_a_inside & ev.hit_b_inside;
                event_q = {event_q, ev};
            end
            if (i_m_valid && i_m_ready) begin
                got = i_m_data[$bits(t_event_out)-1:0];
                if (event_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    ev = event_q.pop_front();
                    if (got.ring_a != ev.ring_a) report("ring_a", got.ring_a, ev.ring_a);
                    if (got.det_a != ev.det_a) report("det_a", got.det_a, ev.det_a);
                    if (got.ring_b != ev.ring_b) report("ring_b", got.ring_b, ev.ring_b);
                    if (got.det_b != ev.det_b) report("det_b", got.det_b, ev.det_b);
                    if (got.hit_a_inside != ev.hit_a_inside)
                        report("hit_a_inside", got.hit_a_inside, ev.hit_a_inside);
                    if (got.hit_b_inside != ev.hit_b_inside)
                        report("hit_b_inside", got.hit_b_inside, ev.hit_b_inside);
                    if (got.event_valid != ev.event_valid)
                        report("event_valid", got.event_valid, ev.event_valid);
                end
            end
        end
        o_pending = event_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule

>>> tb/tb_coincidence_hit_to_ring_detector.sv
`timescale 1ns / 100ps
// testbench top for the ring detector: clock, reset, cfg phases, event stimulus
// depends on chrd_pkg, the block and tb_chrd_checker
module tb_coincidence_hit_to_ring_detector;
    import chrd_pkg::*;

    localparam int CB = 20;
    localparam int IN_W = ((6*CB+7)/8)*8;
    localparam int OUT_W = ((2*(12+8)+3+7)/8)*8;
    localparam int LATENCY = 37;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0] i_cfg_idx = '0;
    logic [CfgDataBits-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // hit_a_x, hit_a_y, hit_a_z, hit_b_x, hit_b_y, hit_b_z from bit 0, zero pad
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // ring_a, det_a, ring_b, det_b, hit_a_inside, hit_b_inside, event_valid
    logic [OUT_W-1:0] m_axis_tdata;
    int errors, pending;
    longint cycles = 0;
    bit stall_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    coincidence_hit_to_ring_detector DUT (.*);

    tb_chrd_checker u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog on total cycles
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_coincidence_hit_to_ring_detector: errors");
            $finish;
        end
    end

    // receiver back-pressure: a rotating pattern mixed with random stalls
    logic [6:0] stall_phase = '0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 7'd1;
        if (!stall_on || stall_phase[6]) m_axis_tready <= 1'b1;
        else m_axis_tready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(3) != 0);
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CfgDataBits-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // one request: holds tvalid until the block takes it
    task automatic send_event(input logic [CB-1:0] ax, ay, az, bx, by, bz);
        i_cfg_we <= 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'({bz, by, bx, az, ay, ax});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] coord_near(input int r);
        // mostly around the ring radius, sometimes anywhere
        int v;
        if ($urandom_range(3) == 0) return CB'($urandom);
        v = $urandom_range(r + 2000) - (r + 2000) / 2 * $urandom_range(2);
        return CB'(($urandom_range(1) ? v : -v));
    endfunction

    task automatic random_burst(input int count, input int r);
        int burst;
        logic [CB-1:0] c[6];
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(4)) @(posedge i_clk);
                burst = $urandom_range(1, 20);
            end
            burst--;
            foreach (c[j]) c[j] = coord_near(r);
            // sometimes place hits on an axis
            if ($urandom_range(9) == 0) c[1] = '0;
            if ($urandom_range(9) == 0) c[3] = '0;
            if ($urandom_range(15) == 0) c[2] = '0;
            send_event(c[0], c[1], c[2], c[3], c[4], c[5]);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: axes, origin, extremes of each coordinate, defaults
        send_event('0, '0, '0, '0, '0, '0);
        send_event(20'd112000, '0, 20'd1, -20'sd112000, '0, -20'sd1);
        send_event('0, 20'd112000, 20'd128000, '0, -20'sd112000, 20'd127999);
        send_event(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000);
        send_event(20'h80000, 20'h7FFFF, '0, 20'h7FFFF, 20'h80000, 20'h7FFFF);
        send_event(20'd79195, 20'd79195, 20'd500, -20'sd79195, 20'd79195, 20'd64000);
        send_event(20'd112000 + 20'd896, '0, 20'd5, 20'd112000 - 20'd896, '0, 20'd5);
        send_event(20'd112897, '0, 20'd5, 20'd111103, '0, 20'd5);
        send_event(20'd1, -20'sd1, 20'd3, -20'sd1, 20'd1, -20'sd3);
        s_axis_tvalid <= 1'b0;
        drain();

        // phase: many rings, fine sectors, coercion on
        write_reg(REG_RINGS, 20'd256);
        write_reg(REG_DETECTORS, 20'd4096);
        write_reg(REG_COERCE, 20'd1);
        write_reg(REG_AXIAL, 20'd1000);
        send_event(20'd112000, '0, 20'd999, '0, 20'd112000, 20'd1000);
        send_event(20'd112000, '0, -20'sd5, '0, 20'd112000, 20'h7FFFF);
        random_burst(200, 112000);
        drain();

        // phase: extremes of the registers, coercion off
        write_reg(REG_COERCE, 20'd0);
        write_reg(REG_RADIUS, 20'h7FFFF);
        write_reg(REG_STRIP, 20'hFFFF);
        write_reg(REG_DETECTORS, 20'd1);
        write_reg(REG_RINGS, 20'd1);
        write_reg(REG_AXIAL, 20'hFFFFF);
        random_burst(150, 524287);
        drain();

        // phase: degenerate zeros
        write_reg(REG_RADIUS, 20'd0);
        write_reg(REG_STRIP, 20'd0);
        write_reg(REG_DETECTORS, 20'd0);
        write_reg(REG_RINGS, 20'd0);
        write_reg(REG_AXIAL, 20'd0);
        send_event('0, '0, 20'd1, 20'd1, '0, -20'sd1);
        random_burst(100, 200);
        drain();

        // phase: mid settings, receiver never stalls for a while
        stall_on = 1'b0;
        write_reg(REG_RADIUS, 20'd50000);
        write_reg(REG_STRIP, 20'd3000);
        write_reg(REG_DETECTORS, 20'd97);
        write_reg(REG_RINGS, 20'd37);
        write_reg(REG_AXIAL, 20'd300000);
        random_burst(150, 50000);
        stall_on = 1'b1;
        drain();

        write_reg(REG_COERCE, 20'd1);
        write_reg(REG_RINGS, 20'd200);
        write_reg(REG_AXIAL, 20'd77777);
        write_reg(REG_DETECTORS, 20'd4095);
        random_burst(390, 50000);
        drain();

        if (errors == 0)
            $display("tb_coincidence_hit_to_ring_detector: clean");
        else
            $display("tb_coincidence_hit_to_ring_detector: errors");
        $finish;
    end
endmodule
